/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Invariant at every edge.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

/* design/psx_pkg.sv */
// ----------------------------------------------------------------------------
// psx_pkg
// Types, constants and helpers shared by the string extractor modules.
// ----------------------------------------------------------------------------
package psx_pkg;

  localparam int MAX_MIN_LEN = 16;
  localparam int HOLD_DEPTH  = MAX_MIN_LEN - 1;
  localparam int RL_W        = $clog2(MAX_MIN_LEN + 1);
  localparam int IDX_W       = $clog2(HOLD_DEPTH);
  localparam int CFG_W       = 5;

  localparam logic [CFG_W-1:0] MIN_LEN_RESET = 5'd4;
  localparam logic [7:0]       CHAR_TAB      = 8'h09;
  localparam logic [7:0]       CHAR_LO       = 8'h20;
  localparam logic [7:0]       CHAR_HI       = 8'h7E;

  // Register index of min_length.
  localparam logic REG_MIN_LENGTH = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_end_marker;
    logic       string_start;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_CHAR,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_HOLD,
    EMIT_CHAR,
    EMIT_END
  } emit_kind_t;

  typedef struct packed {
    logic       latch;
    logic       store;
    logic       set_sat;
    logic       clr_run;
    logic       set_first;
    emit_kind_t emit;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic printable;
    logic run_lt;
    logic run_eq;
    logic run_ge;
    logic run_zero;
    logic slot_free;
    logic flush_done;
    logic flush_ok;
    logic in_last;     // final flag of the offered request
    logic last_flag;   // final flag of the latched request
  } stat_t;

  function automatic logic is_printable(input logic [7:0] b);
    return ((b >= CHAR_LO) && (b <= CHAR_HI)) || (b == CHAR_TAB);
  endfunction

endpackage

/* design/psx_ctrl.sv */
// ----------------------------------------------------------------------------
// psx_ctrl
// Sequencer: classifies each request and steps the flush and emit phases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psx_ctrl import psx_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  src_valid,
  output logic  src_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    src_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        src_ready = 1'b1;
        if (src_valid) begin
          if (stat.printable) begin
            if (stat.run_lt) begin
              // Hold the byte back; a final byte drops the short run.
              cmd.store   = ~stat.in_last;
              cmd.clr_run = stat.in_last;
            end else if (stat.run_eq) begin
              cmd.latch     = 1'b1;
              cmd.set_first = 1'b1;
              cmd.set_sat   = ~stat.in_last;
              cmd.clr_run   = stat.in_last;
              state_next    = stat.run_zero ? ST_CHAR : ST_FLUSH;
            end else begin
              cmd.latch   = 1'b1;
              cmd.clr_run = stat.in_last;
              state_next  = ST_CHAR;
            end
          end else begin
            cmd.clr_run = 1'b1;
            if (stat.run_ge) begin
              cmd.latch  = 1'b1;
              state_next = ST_END;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (stat.slot_free) begin
          cmd.emit = EMIT_HOLD;
          if (stat.flush_done) begin
            state_next = ST_CHAR;
          end
        end
      end
      ST_CHAR: begin
        if (stat.slot_free) begin
          cmd.emit      = EMIT_CHAR;
          cmd.emit_last = ~stat.last_flag;
          state_next    = stat.last_flag ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        if (stat.slot_free) begin
          cmd.emit      = EMIT_END;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPL(a_flush_has_bytes, state == ST_FLUSH, stat.flush_ok)

endmodule

/* design/psx_datapath.sv */
// ----------------------------------------------------------------------------
// psx_datapath
// Run counter, hold buffer, min_length register and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psx_datapath import psx_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  in_item_t         src_item,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output logic [CFG_W-1:0] cfg_value,
  output logic             res_valid,
  input  logic             res_ready,
  output out_item_t        res_item
);

  logic [CFG_W-1:0] min_len;
  logic [RL_W-1:0]  rl;
  logic [RL_W-1:0]  rl_c;
  logic [RL_W-1:0]  m_eff;
  logic [IDX_W-1:0] idx;
  logic [7:0]       byte_reg;
  logic             last_reg;
  logic             first;
  logic [7:0]       hold [HOLD_DEPTH];

  // Clamp the minimum to 1..MAX_MIN_LEN.
  always_comb begin
    if (min_len == '0) begin
      m_eff = RL_W'(1);
    end else if ({{(RL_W > CFG_W ? RL_W - CFG_W : 0){1'b0}}, min_len} >
                 RL_W'(MAX_MIN_LEN)) begin
      m_eff = RL_W'(MAX_MIN_LEN);
    end else begin
      m_eff = RL_W'(min_len);
    end
    rl_c = (rl > m_eff) ? m_eff : rl;
  end

  always_comb begin
    stat.printable  = is_printable(src_item.data_byte);
    stat.run_lt     = ({1'b0, rl_c} + (RL_W+1)'(1)) < {1'b0, m_eff};
    stat.run_eq     = ({1'b0, rl_c} + (RL_W+1)'(1)) == {1'b0, m_eff};
    stat.run_ge     = rl_c >= m_eff;
    stat.run_zero   = rl_c == '0;
    stat.slot_free  = ~res_valid | res_ready;
    stat.flush_done = {{(RL_W-IDX_W){1'b0}}, idx} == (m_eff - RL_W'(2));
    stat.flush_ok   = m_eff >= RL_W'(2);
    // In the idle state the final flag comes straight from the request.
    stat.in_last    = src_item.buffer_end;
    stat.last_flag  = last_reg;
  end

  assign cfg_value = min_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RESET;
      rl      <= '0;
    end else begin
      if (cfg_we) begin
        min_len <= cfg_data;
        rl      <= '0;
      end else if (cmd.clr_run) begin
        rl <= '0;
      end else if (cmd.set_sat) begin
        rl <= m_eff;
      end else if (cmd.store) begin
        rl <= rl_c + RL_W'(1);
      end
    end
  end

  // Hold buffer: undefined until written, no reset.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      hold[rl_c[IDX_W-1:0]] <= src_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      first <= 1'b0;
    end else begin
      if (cmd.latch) begin
        idx   <= '0;
        first <= cmd.set_first;
      end else if (cmd.emit == EMIT_HOLD) begin
        idx   <= idx + IDX_W'(1);
        first <= 1'b0;
      end else if (cmd.emit == EMIT_CHAR) begin
        first <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_reg <= src_item.data_byte;
      last_reg <= src_item.buffer_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_HOLD: begin
        res_item <= '{out_char: hold[idx], is_end_marker: 1'b0,
                      string_start: first, last_of_run: 1'b0};
      end
      EMIT_CHAR: begin
        res_item <= '{out_char: byte_reg, is_end_marker: 1'b0,
                      string_start: first, last_of_run: cmd.emit_last};
      end
      EMIT_END: begin
        res_item <= '{out_char: 8'h00, is_end_marker: 1'b1,
                      string_start: 1'b0, last_of_run: 1'b1};
      end
      default: begin
        res_item <= res_item;
      end
    endcase
  end

  `ASSERT_IMPL(a_emit_into_free_slot, cmd.emit != EMIT_NONE, !res_valid || res_ready)
  `ASSERT_NEXT(a_emit_shows_valid, cmd.emit != EMIT_NONE, res_valid)
  `ASSERT_ALWAYS(a_run_bounded, rl <= RL_W'(MAX_MIN_LEN))

endmodule

/* design/printable_string_extractor_unit.sv */
// A held or dropped byte is taken in the idle state alone; a passed byte also goes through
// the char state, and the byte that completes a run flushes the held bytes first; a
// closing end marker adds the end state. No new byte is taken until these are emitted.
// The sequencer emits one result per cycle into one register while that register is free.
// Reset (rst, synchronous): run count clears, min_length returns to 4, result register
// empties; the hold buffer is not cleared.
// ----------------------------------------------------------------------------
// printable_string_extractor_unit
// Finds runs of printable bytes of at least min_length and streams them out.
// ----------------------------------------------------------------------------
module printable_string_extractor_unit import psx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Byte request channel
  input  logic        src_valid,
  output logic        src_ready,
  input  in_item_t    src_item,
  // Result channel
  output logic        res_valid,
  input  logic        res_ready,
  output out_item_t   res_item,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t             cmd;
  stat_t            stat;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_value;
  logic             ctrl_src_ready;

  // Decode the register port: one register, word addressed.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_MIN_LENGTH);
  assign prdata = (paddr[2] == REG_MIN_LENGTH) ? {{(32-CFG_W){1'b0}}, cfg_value} : 32'd0;

  // Only accept a byte request when the sequencer is idle.
  assign src_ready = ctrl_src_ready;

  psx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (ctrl_src_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the run state and drive the result register.
  psx_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .src_item  (src_item),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_data  (pwdata[CFG_W-1:0]),
    .cfg_value (cfg_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

/* dv/psx_string_checker.sv */
// ----------------------------------------------------------------------------
// psx_string_checker
// Watches the byte and result channels and the register port of the string
// extractor, predicts the result stream and compares it result by result.
// ----------------------------------------------------------------------------
module psx_string_checker import psx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  input  logic        src_ready,
  input  in_item_t    src_item,
  input  logic        res_valid,
  input  logic        res_ready,
  input  out_item_t   res_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [2:0] MIN_LENGTH_ADDR = {REG_MIN_LENGTH, 2'b00};
  localparam out_item_t  END_MARKER      = '{out_char: 8'h00, is_end_marker: 1'b1,
                                             string_start: 1'b0, last_of_run: 1'b0};

  logic [CFG_W-1:0] min_length_q = MIN_LEN_RESET;
  logic [RL_W-1:0]  run_count    = '0;
  logic [7:0]       held_chars [HOLD_DEPTH];
  out_item_t        string_stream_q [$];
  out_item_t        want;
  int               fault_count  = 0;
  int               result_count = 0;

  function automatic out_item_t char_result(input logic [7:0] ch, input logic first);
    return '{out_char: ch, is_end_marker: 1'b0, string_start: first, last_of_run: 1'b0};
  endfunction

  // Work out every result that one accepted byte causes and queue them in order.
  task automatic scan_byte(input in_item_t req);
    out_item_t burst [$];
    int        floor_len;
    bit        printable;
    floor_len = (min_length_q == 0) ? 1 :
                (min_length_q > MAX_MIN_LEN) ? MAX_MIN_LEN : int'(min_length_q);
    printable = (req.data_byte >= CHAR_LO && req.data_byte <= CHAR_HI) ||
                req.data_byte == CHAR_TAB;
    if (run_count > floor_len) run_count = RL_W'(floor_len);
    if (printable) begin
      if (run_count + 1 < floor_len) begin
        // hold until the run is long enough
        if (run_count < HOLD_DEPTH) held_chars[run_count] = req.data_byte;
        run_count = run_count + 1'b1;
      end else if (run_count + 1 == floor_len) begin
        // run qualifies: flush the held bytes, then this one
        for (int i = 0; i < run_count && i < HOLD_DEPTH; i++)
          burst = {burst, char_result(held_chars[i], burst.size() == 0)};
        burst = {burst, char_result(req.data_byte, burst.size() == 0)};
        run_count = RL_W'(floor_len);
      end else begin
        burst = {burst, char_result(req.data_byte, 1'b0)};
      end
      if (req.buffer_end) begin
        if (run_count >= floor_len) burst = {burst, END_MARKER};
        run_count = '0;
      end
    end else begin
      if (run_count >= floor_len) burst = {burst, END_MARKER};
      run_count = '0;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last_of_run = 1'b1;
    string_stream_q = {string_stream_q, burst};
  endtask

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] result %0d: %s", $time, result_count, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      min_length_q = MIN_LEN_RESET;
      run_count    = '0;
      string_stream_q.delete();
    end else begin
      // a write to min_length abandons the current run
      if (psel && penable && pwrite && pready && paddr == MIN_LENGTH_ADDR) begin
        min_length_q = pwdata[CFG_W-1:0];
        run_count    = '0;
      end
      if (src_valid && src_ready) scan_byte(src_item);
      if (res_valid && res_ready) begin
        if (string_stream_q.size() == 0) begin
          note_fault($sformatf("arrived with nothing predicted (char %02h end %b start %b last %b)",
                               res_item.out_char, res_item.is_end_marker,
                               res_item.string_start, res_item.last_of_run));
        end else begin
          want = string_stream_q.pop_front();
          if (res_item.out_char !== want.out_char ||
              res_item.is_end_marker !== want.is_end_marker ||
              res_item.string_start !== want.string_start ||
              res_item.last_of_run !== want.last_of_run) begin
            note_fault($sformatf({"differs: expected char %02h end %b start %b last %b, ",
                                  "got char %02h end %b start %b last %b"},
                                 want.out_char, want.is_end_marker,
                                 want.string_start, want.last_of_run,
                                 res_item.out_char, res_item.is_end_marker,
                                 res_item.string_start, res_item.last_of_run));
          end
        end
        result_count++;
      end
    end
    mismatches  <= fault_count;
    outstanding <= string_stream_q.size();
  end

endmodule

/* dv/tb_printable_string_extractor_unit.sv */
// ----------------------------------------------------------------------------
// tb_printable_string_extractor_unit
// Feeds byte streams of text runs, binary noise and buffer ends through the
// string extractor under several minimum lengths, with random idling on both
// channels; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_printable_string_extractor_unit;
  import psx_pkg::*;

  localparam int         TIMEOUT_CYCLES  = 500000;
  localparam int         SETTLE_CYCLES   = 24;
  localparam logic [2:0] MIN_LENGTH_ADDR = {REG_MIN_LENGTH, 2'b00};
  // next register slot: nothing lives there
  localparam logic [2:0] SPARE_ADDR      = {~REG_MIN_LENGTH, 2'b00};

  // How a generated text run is closed.
  typedef enum int {
    CLOSE_BINARY,
    CLOSE_FINAL_TEXT,
    CLOSE_FINAL_BINARY,
    CLOSE_OPEN
  } run_close_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_ready;
  in_item_t    src_item  = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  out_item_t   res_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int stall_left  = 0;
  int bytes_sent  = 0;
  int run_floor   = 4;    // effective minimum that run lengths are aimed at
  bit calm        = 1'b0; // no idling on either side when set

  printable_string_extractor_unit uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  psx_string_checker stream_check (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_ready   (src_ready),
    .src_item    (src_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stop a hung run.
  initial begin
    while (cycle_count < TIMEOUT_CYCLES) @(posedge clk) cycle_count++;
    $display("Mismatches found");
    $finish;
  end

  // Result side: now and then drop ready at random, hold it high otherwise.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      res_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      res_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 9) == 0) return CHAR_TAB;
    return 8'($urandom_range(CHAR_LO, CHAR_HI));
  endfunction

  // Any byte outside the printable set: control codes and the upper half.
  function automatic logic [7:0] binary_char();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, CHAR_TAB - 1));
      1:       return 8'($urandom_range(CHAR_TAB + 1, CHAR_LO - 1));
      default: return 8'($urandom_range(CHAR_HI + 1, 255));
    endcase
  endfunction

  // Offer one byte request and hold it until the block takes it. Enter and
  // leave right after a rising edge.
  task automatic send_byte(input logic [7:0] value, input logic closing);
    if (!calm && $urandom_range(0, 4) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= '{data_byte: value, buffer_end: closing};
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_run(input int len, input run_close_t closing);
    for (int i = 0; i < len; i++)
      send_byte(text_char(), closing == CLOSE_FINAL_TEXT && i == len - 1);
    if (closing == CLOSE_BINARY) send_byte(binary_char(), 1'b0);
    else if (closing == CLOSE_FINAL_BINARY) send_byte(binary_char(), 1'b1);
  endtask

  // Mostly well-formed text runs around the current minimum; the rest is noise.
  task automatic scan_phase(input int count);
    int goal;
    goal = bytes_sent + count;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 3) != 0) begin
        send_run($urandom_range(0, run_floor + 3), run_close_t'($urandom_range(0, 3)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Hold off until every predicted result is out and the block has gone quiet.
  task automatic wait_quiet();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register while the block is idle; upper data bits carry junk.
  task automatic reconfigure(input logic [2:0] addr, input logic [CFG_W-1:0] value);
    src_valid <= 1'b0;
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(32 - CFG_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == MIN_LENGTH_ADDR)
      run_floor = (value == 0) ? 1 : (value > MAX_MIN_LEN) ? MAX_MIN_LEN : int'(value);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset minimum of 4.
    // Tab and both printable limits, completed by the fourth byte: flush.
    send_byte(8'h20, 1'b0); send_byte(CHAR_TAB, 1'b0);
    send_byte(8'h7E, 1'b0); send_byte(8'h41, 1'b0);
    // Pass one through, then close on DEL.
    send_byte(8'h42, 1'b0); send_byte(8'h7F, 1'b0);
    // Short run dropped by a control code.
    send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b0); send_byte(8'h1F, 1'b0);
    // Completing byte is also the buffer's final byte.
    send_byte(8'h61, 1'b0); send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0); send_byte(8'h64, 1'b1);
    // Printable final byte on a run too short to report.
    send_byte(8'h7E, 1'b1);
    // Non-printable final byte after a reported run.
    send_byte(8'h21, 1'b0); send_byte(8'h22, 1'b0); send_byte(8'h23, 1'b0);
    send_byte(8'h24, 1'b0); send_byte(8'hFF, 1'b1);
    // Non-printable final byte with no run open.
    send_byte(8'h80, 1'b1);
    // Leave a run half held; the next register write must abandon it.
    send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b0); send_byte(8'h43, 1'b0);

    // Random part over several minimum lengths, extremes first.
    reconfigure(MIN_LENGTH_ADDR, 5'd0);
    scan_phase(20);
    reconfigure(SPARE_ADDR, 5'd7);
    scan_phase(15);
    reconfigure(MIN_LENGTH_ADDR, 5'd16);
    scan_phase(40);
    reconfigure(MIN_LENGTH_ADDR, 5'd31);
    scan_phase(20);
    reconfigure(MIN_LENGTH_ADDR, 5'd1);
    scan_phase(20);
    repeat (2) begin
      reconfigure(MIN_LENGTH_ADDR, 5'($urandom_range(2, 30)));
      scan_phase(20);
    end
    // Last stretch back at the default, flat out on both sides.
    reconfigure(MIN_LENGTH_ADDR, MIN_LEN_RESET);
    calm = 1'b1;
    scan_phase(20);

    src_valid <= 1'b0;
    wait_quiet();
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/psx_pkg.sv
design/psx_ctrl.sv
design/psx_datapath.sv
design/printable_string_extractor_unit.sv
dv/psx_string_checker.sv
dv/tb_printable_string_extractor_unit.sv
